@@ hw/rtl/msb_first_bit_reader_defines.svh @@
// Assertion macros used by the checker file.
`ifndef MSB_FIRST_BIT_READER_DEFINES_SVH
`define MSB_FIRST_BIT_READER_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define MFBR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, gated off during reset.
`define MFBR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked in reset too.
`define MFBR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/mfbr_pkg.sv @@
package mfbr_pkg;

   localparam int STORE_BITS = 128;
   localparam int FILL_W     = $clog2(STORE_BITS + 1);
   localparam int CMP_W      = FILL_W + 1;
   localparam int BYTE_W     = 8;
   localparam int VALUE_W    = 64;

   localparam logic       OP_PUSH  = 1'b0;
   localparam logic       OP_READ  = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic       opcode;
      logic [7:0] byte_in;
      logic [5:0] skip_bits;
      logic [6:0] read_bits;
   } req_type;

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  status;
      logic [31:0] bit_position;
      logic [7:0]  bits_held;
   } rsp_type;

endpackage

@@ hw/rtl/msb_first_bit_reader.sv @@
// MSB-first bit-stream reader.
// Input channel req_*: one transaction per valid && !stall edge. A push
// (opcode 0) appends byte_in to the bit store, oldest bit first; a read
// (opcode 1) drops skip_bits bits, then returns the next read_bits bits
// right aligned, first bit most significant.
// Result channel rsp_*: exactly one transaction per input transaction, in order,
// with status (ok, short, full), running consumed-bit position and fill level.
// An accepted transaction passes the input register, then a barrel shifter into
// the result register together with the store update; a stalled result keeps it
// waiting in the input register. The reader takes one transaction per cycle while
// no result stalls; the store shift and the fill/total compare set the critical path.
// A new transaction is taken while a result waits, as long as the input
// register is free or moving on. A stalled result holds, and the input
// register holds behind it; req_stall rises only when both are occupied.
// Reset (synchronous, active high) clears the store, fill level and
// position counter and empties both registers; no clearing pass is needed.
module msb_first_bit_reader (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mfbr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mfbr_pkg::rsp_type rsp_data
);

   logic                                in_valid_ff, in_valid_in;
   mfbr_pkg::req_type                   in_data_ff;
   logic                                out_valid_ff, out_valid_in;
   mfbr_pkg::rsp_type                   out_data_ff, out_data_in;
   logic [mfbr_pkg::STORE_BITS-1:0]     store_ff, store_in;
   logic [mfbr_pkg::FILL_W-1:0]         fill_ff, fill_in;
   logic [31:0]                         consumed_ff, consumed_in;

   logic                                out_free;
   logic                                advance;
   logic                                take_req;
   logic [mfbr_pkg::CMP_W-1:0]          fill_ext;
   logic [mfbr_pkg::CMP_W-1:0]          total;
   logic [mfbr_pkg::CMP_W-1:0]          shamt;
   logic [mfbr_pkg::STORE_BITS-1:0]     field_all;
   logic [mfbr_pkg::STORE_BITS-1:0]     push_bits;
   logic [mfbr_pkg::VALUE_W-1:0]        mask;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take_req  = req_valid && !req_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign fill_ext  = mfbr_pkg::CMP_W'(fill_ff);
   assign total     = mfbr_pkg::CMP_W'(in_data_ff.skip_bits)
                    + mfbr_pkg::CMP_W'(in_data_ff.read_bits);
   assign shamt     = mfbr_pkg::CMP_W'(mfbr_pkg::STORE_BITS) - total;
   assign field_all = store_ff >> shamt;
   assign mask      = in_data_ff.read_bits[6] ? {mfbr_pkg::VALUE_W{1'b1}}
                    : ~({mfbr_pkg::VALUE_W{1'b1}} << in_data_ff.read_bits[5:0]);
   assign push_bits = {in_data_ff.byte_in,
                       {(mfbr_pkg::STORE_BITS - mfbr_pkg::BYTE_W){1'b0}}} >> fill_ff;

   always_comb begin
      store_in    = store_ff;
      fill_in     = fill_ff;
      consumed_in = consumed_ff;
      out_data_in = out_data_ff;
      if (advance) begin
         out_data_in.value  = '0;
         out_data_in.status = mfbr_pkg::ST_OK;
         case (in_data_ff.opcode)
            mfbr_pkg::OP_PUSH: begin
               if (fill_ext + mfbr_pkg::CMP_W'(mfbr_pkg::BYTE_W)
                   <= mfbr_pkg::CMP_W'(mfbr_pkg::STORE_BITS)) begin
                  store_in = store_ff | push_bits;
                  fill_in  = fill_ff + mfbr_pkg::FILL_W'(mfbr_pkg::BYTE_W);
               end else begin
                  out_data_in.status = mfbr_pkg::ST_FULL;
               end
            end
            mfbr_pkg::OP_READ: begin
               if (total > fill_ext) begin
                  out_data_in.status = mfbr_pkg::ST_SHORT;
               end else begin
                  out_data_in.value = field_all[mfbr_pkg::VALUE_W-1:0] & mask;
                  store_in          = store_ff << total;
                  fill_in           = fill_ff - mfbr_pkg::FILL_W'(total);
                  consumed_in       = consumed_ff + 32'(total);
               end
            end
            default: begin
               out_data_in.status = mfbr_pkg::ST_OK;
            end
         endcase
         out_data_in.bit_position = consumed_in;
         out_data_in.bits_held    = 8'(fill_in);
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take_req) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         store_ff     <= '0;
         fill_ff      <= '0;
         consumed_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         store_ff     <= store_in;
         fill_ff      <= fill_in;
         consumed_ff  <= consumed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_data_ff <= req_data;
      end
      out_data_ff <= out_data_in;
   end

endmodule

@@ hw/rtl/mfbr_checker.sv @@
`include "msb_first_bit_reader_defines.svh"

module mfbr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mfbr_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mfbr_pkg::rsp_type rsp_data
);

   logic req_held;
   logic rsp_held;
   logic rsp_fail;

   assign req_held = req_valid && req_stall;
   assign rsp_held = rsp_valid && rsp_stall;
   assign rsp_fail = rsp_valid && rsp_data.status != mfbr_pkg::ST_OK;

   `MFBR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))
   `MFBR_ASSERT_NEXT(a_req_hold, clock, reset, req_held, req_valid && $stable(req_data))
   `MFBR_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   `MFBR_ASSERT_NOW(a_fail_zero, clock, reset, rsp_fail, rsp_data.value == '0)
   `MFBR_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind msb_first_bit_reader mfbr_checker u_mfbr_checker (.*);
